[rtl/ctti_pkg.sv]
// Shared constants, breakpoint table, types and helpers for the current-to-torque interpolator.
// No dependencies; every module of the block imports this package.
package ctti_pkg;

  // Breakpoints in use (2 to 64); the last one in use is where extrapolation starts
  localparam int TABLE_POINTS   = 25;
  localparam int MAX_POINTS     = 64;
  localparam int NPTS           = (TABLE_POINTS < 2) ? 2 :
                                  ((TABLE_POINTS > MAX_POINTS) ? MAX_POINTS : TABLE_POINTS);
  localparam int LAST           = NPTS - 1;
  localparam int IDX_W          = $clog2(MAX_POINTS);

  // Port field widths
  localparam int IQ_W           = 16;  // signed Q12.4 A
  localparam int TQ_W           = 15;  // unsigned Q7.8 Nm
  localparam int REGION_W       = 2;
  localparam int S_TDATA_W      = 16;
  localparam int M_TDATA_W      = 24;

  // Internal widths; currents in 1/160 A
  localparam int XS_W           = 19;  // 32767 * 10
  localparam int BP_W           = 17;  // 5470 * 16
  localparam int X_W            = 21;  // 4 * d + 25 for extrapolation
  localparam int NUM_W          = BP_W + 9;
  localparam int DEN_W          = BP_W + 1;
  localparam int QDIV_W         = 8;   // interpolation step is at most 128
  localparam int QEXT_W         = 16;
  localparam int TORQUE_STEP_SH = 7;   // 0.5 Nm = 128 in Q7.8
  localparam int BASE_W         = IDX_W + TORQUE_STEP_SH;
  localparam int SUM_W          = QEXT_W + 1;

  // floor(x / 50) = (x * ceil(2^27 / 50)) >> 27, exact for x < 2^21
  localparam int                RECIP_W  = 22;
  localparam logic [RECIP_W-1:0] RECIP_M = 22'd2684355;
  localparam int                RECIP_SH = 27;
  localparam int                PROD_W   = X_W + RECIP_W;
  localparam logic [X_W-1:0]    EXT_RND  = 21'd25;

  localparam logic [TQ_W-1:0]   TORQUE_MAX = '1;

  // Current breakpoints in tenths of an ampere
  localparam logic [12:0] BRK_DECI [MAX_POINTS] = '{
    13'd0,    13'd58,   13'd110,  13'd165,  13'd220,  13'd273,  13'd327,  13'd380,
    13'd435,  13'd490,  13'd548,  13'd605,  13'd664,  13'd730,  13'd795,  13'd860,
    13'd930,  13'd1000, 13'd1050, 13'd1120, 13'd1200, 13'd1280, 13'd1370, 13'd1470,
    13'd1570, 13'd1670, 13'd1770, 13'd1870, 13'd1970, 13'd2070, 13'd2170, 13'd2270,
    13'd2370, 13'd2470, 13'd2570, 13'd2670, 13'd2770, 13'd2870, 13'd2970, 13'd3070,
    13'd3170, 13'd3270, 13'd3370, 13'd3470, 13'd3570, 13'd3670, 13'd3770, 13'd3870,
    13'd3970, 13'd4070, 13'd4170, 13'd4270, 13'd4370, 13'd4470, 13'd4570, 13'd4670,
    13'd4770, 13'd4870, 13'd4970, 13'd5070, 13'd5170, 13'd5270, 13'd5370, 13'd5470
  };

  typedef enum logic [REGION_W-1:0] {
    REG_NEG = 2'd0,
    REG_TAB = 2'd1,
    REG_EXT = 2'd2
  } region_e;

  // Segment found by the front end
  typedef struct packed {
    region_e           region;
    logic              interp;
    logic [BASE_W-1:0] base;
    logic [BP_W-1:0]   d;
    logic [BP_W-1:0]   w;
    logic [X_W-1:0]    x;
  } seg_t;

  // Divider stage contents
  typedef struct packed {
    region_e           region;
    logic              interp;
    logic [BASE_W-1:0] base;
    logic [NUM_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [QDIV_W-1:0] quo;
    logic [QEXT_W-1:0] qext;
  } div_t;

  // Breakpoint in 1/160 A
  function automatic logic [BP_W-1:0] bp16(input logic [IDX_W-1:0] k);
    return {BRK_DECI[k], 4'b0000};
  endfunction

endpackage

[rtl/ctti_front.sv]
// Front end: sample scaling, parallel breakpoint compare, then segment selection.
// Two register stages; depends on ctti_pkg.
module ctti_front
  import ctti_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [IQ_W-1:0] iq_i,
  output logic            ready_o,
  output logic            valid_o,
  output seg_t            seg_o,
  input  logic            ready_i
);

  // stage A
  logic            va_q;
  logic            nega_q, nega_d;
  logic [XS_W-1:0] xs_q, xs_d;
  logic [NPTS-1:0] le_q, le_d;
  // stage B
  logic            vb_q;
  seg_t            seg_q, seg_d;

  logic            rdy_a, rdy_b;
  logic [IDX_W-1:0] k;
  logic [BP_W-1:0]  hi, lo;
  logic             exact;
  logic [XS_W-1:0]  xdiff;

  assign rdy_b   = !vb_q || ready_i;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;

  // sample * 10 as shift-add, then compare against every breakpoint in use
  always_comb begin
    nega_d = iq_i[IQ_W-1];
    xs_d   = {1'b0, iq_i[IQ_W-2:0], 3'b000} + {3'b000, iq_i[IQ_W-2:0], 1'b0};
    for (int i = 0; i < NPTS; i++) begin
      le_d[i] = (xs_d <= {{(XS_W-BP_W){1'b0}}, bp16(IDX_W'(i))});
    end
  end

  // first breakpoint not below the sample
  always_comb begin
    k = IDX_W'(LAST);
    for (int i = NPTS - 1; i >= 0; i--) begin
      if (le_q[i]) begin
        k = IDX_W'(i);
      end
    end
  end

  always_comb begin
    hi    = bp16(k);
    lo    = bp16(k - 1'b1);
    exact = (k == '0) || (xs_q == {{(XS_W-BP_W){1'b0}}, hi});
    xdiff = xs_q - {{(XS_W-BP_W){1'b0}}, bp16(IDX_W'(LAST))};

    seg_d        = '0;
    seg_d.region = REG_NEG;
    if (nega_q) begin
      seg_d.region = REG_NEG;
    end else if (le_q[LAST]) begin
      seg_d.region = REG_TAB;
      seg_d.interp = !exact;
      seg_d.base   = exact ? {k, {TORQUE_STEP_SH{1'b0}}}
                           : {k - 1'b1, {TORQUE_STEP_SH{1'b0}}};
      seg_d.d      = xs_q[BP_W-1:0] - lo;
      seg_d.w      = hi - lo;
    end else begin
      seg_d.region = REG_EXT;
      seg_d.base   = {IDX_W'(LAST), {TORQUE_STEP_SH{1'b0}}};
      seg_d.x      = {xdiff[X_W-3:0], 2'b00} + EXT_RND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      nega_q <= nega_d;
      xs_q   <= xs_d;
      le_q   <= le_d;
    end
    if (rdy_b && va_q) begin
      seg_q <= seg_d;
    end
  end

  assign valid_o = vb_q;
  assign seg_o   = seg_q;

endmodule

[rtl/ctti_div.sv]
// Arithmetic pipeline: operand set-up with the extrapolation multiply, then a
// restoring divider with one quotient bit per stage. Depends on ctti_pkg.
module ctti_div
  import ctti_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  seg_t seg_i,
  output logic ready_o,
  output logic valid_o,
  output div_t res_o,
  input  logic ready_i
);

  localparam int NST = QDIV_W + 1;

  logic            v_q [NST];
  div_t            st_q [NST];
  div_t            st_d [NST];
  logic [NST:0]    rdy;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  trial;

  always_comb begin
    rdy[NST] = ready_i;
    for (int j = NST - 1; j >= 0; j--) begin
      rdy[j] = !v_q[j] || rdy[j+1];
    end
  end
  assign ready_o = rdy[0];

  always_comb begin
    // set-up stage: numerator 256*d + w, denominator 2*w, x/50 by reciprocal
    prod           = PROD_W'(seg_i.x) * PROD_W'(RECIP_M);
    st_d[0].region = seg_i.region;
    st_d[0].interp = seg_i.interp;
    st_d[0].base   = seg_i.base;
    st_d[0].rem    = {1'b0, seg_i.d, 8'h00} + NUM_W'(seg_i.w);
    st_d[0].den    = {seg_i.w, 1'b0};
    st_d[0].quo    = '0;
    st_d[0].qext   = prod[RECIP_SH +: QEXT_W];

    // divider stages, most significant quotient bit first
    trial = '0;
    for (int j = 1; j < NST; j++) begin
      trial   = NUM_W'(st_q[j-1].den) << (NST - 1 - j);
      st_d[j] = st_q[j-1];
      if (st_q[j-1].rem >= trial) begin
        st_d[j].rem              = st_q[j-1].rem - trial;
        st_d[j].quo[NST - 1 - j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NST; j++) v_q[j] <= 1'b0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int j = 1; j < NST; j++) begin
        if (rdy[j]) v_q[j] <= v_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) st_q[0] <= st_d[0];
    for (int j = 1; j < NST; j++) begin
      if (rdy[j] && v_q[j-1]) st_q[j] <= st_d[j];
    end
  end

  assign valid_o = v_q[NST-1];
  assign res_o   = st_q[NST-1];

endmodule

[rtl/current_to_torque_interpolator.sv]
// Current-to-torque interpolator: piecewise linear breakpoint lookup with extrapolation.
// From input transaction to output valid a sample passes two front-end stages,
// one set-up stage, eight divider stages (one quotient bit each), one output register.
// Throughput one transaction per cycle; each stage stalls only when it holds data
// that cannot move on. Reset (rst_ni, asynchronous) clears the valid bits only.
// Depends on ctti_pkg, ctti_front and ctti_div.
module current_to_torque_interpolator
  import ctti_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // sample stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [15:0] iq_current
  // torque stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata    // [14:0] torque_estimate, [16:15] region
);

  logic            f_valid, f_ready;
  seg_t            f_seg;
  logic            d_valid, d_ready;
  div_t            d_res;

  // output register
  logic            ov_q;
  logic [TQ_W-1:0] tq_q, tq_d;
  region_e         reg_q;
  logic            rdy_o;
  logic [SUM_W-1:0] addend, sum;

  // Front end: the compare against every breakpoint in use is flat, the encode and
  // segment fetch follow one stage later.
  ctti_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .iq_i    (s_axis_tdata[IQ_W-1:0]),
    .ready_o (s_axis_tready),
    .valid_o (f_valid),
    .seg_o   (f_seg),
    .ready_i (f_ready)
  );

  // Interpolation quotient round(128*d/w) as (256d + w) div 2w, plus the
  // extrapolation term (4d + 25) div 50 carried alongside.
  ctti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .seg_i   (f_seg),
    .ready_o (f_ready),
    .valid_o (d_valid),
    .res_o   (d_res),
    .ready_i (d_ready)
  );

  assign rdy_o   = !ov_q || m_axis_tready;
  assign d_ready = rdy_o;

  // Base torque of the segment plus the region's step, saturated to Q7.8 max
  always_comb begin
    case (d_res.region)
      REG_EXT: addend = SUM_W'(d_res.qext);
      REG_TAB: addend = d_res.interp ? SUM_W'(d_res.quo) : '0;
      default: addend = '0;
    endcase
    sum  = SUM_W'(d_res.base) + addend;
    tq_d = (sum > SUM_W'(TORQUE_MAX)) ? TORQUE_MAX : sum[TQ_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (rdy_o) begin
      ov_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && d_valid) begin
      tq_q  <= tq_d;
      reg_q <= d_res.region;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {{(M_TDATA_W - TQ_W - REGION_W){1'b0}}, reg_q, tq_q};

  // Negative current always comes out as zero torque
  a_neg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && (reg_q == REG_NEG) |-> (tq_q == '0))
    else $error("negative-current transaction gave non-zero torque");

  // Inside the table torque never passes the last breakpoint's torque
  a_tab_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && (reg_q == REG_TAB) |-> (tq_q <= TQ_W'(LAST << TORQUE_STEP_SH)))
    else $error("interpolated torque beyond table end");

  // Input back-pressure only arises from a blocked output
  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while output not blocked");

  // A blocked output with a full pipeline keeps the input stalled next cycle
  // unless the output is released in that cycle
  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && !m_axis_tready |=> (!s_axis_tready || m_axis_tready))
    else $error("pipeline drained while output blocked");

endmodule

[dv/tb.sv]
// Self-checking testbench for current_to_torque_interpolator: random and directed current samples,
// with a scoreboard class that predicts each torque estimate and checks it.
// Depends on ctti_pkg and the RTL of the block.
module tb
  import ctti_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEP_Q88      = 128;   // 0.5 Nm breakpoint torque step in Q7.8
  localparam int N_RANDOM      = 1700;
  localparam int IDLE_LIMIT    = 4000;  // cycles with no transaction before giving up
  localparam int DRAIN_CYCLES  = 40;    // covers the pipeline depth with margin

  typedef struct packed {
    logic [TQ_W-1:0] torque;
    region_e         region;
  } torque_res_t;

  // Predicts torque estimates for accepted samples and checks results in order
  class torque_scoreboard;
    torque_res_t expected_q[$];
    int          n_errors;
    int          n_checked;
    int          region_hits[3];

    function int brk(input int k);
      return int'(BRK_DECI[k]) * 16;
    endfunction

    function torque_res_t predict(input logic [IQ_W-1:0] bits);
      torque_res_t r;
      int raw, xs, k, lo, hi, w, d, tq;
      raw = int'($signed(bits));
      xs  = raw * 10;  // 1/160 A
      tq  = 0;
      r.region = REG_NEG;
      if (raw < 0) begin
        r.region = REG_NEG;
      end else if (xs <= brk(LAST)) begin
        r.region = REG_TAB;
        k = 0;
        while (k < LAST && xs > brk(k)) k++;
        hi = brk(k);
        if (xs == hi || k == 0) begin
          tq = k * STEP_Q88;
        end else begin
          lo = brk(k - 1);
          w  = hi - lo;
          if (w <= 0) w = 1;
          d  = xs - lo;
          // 128*d/w, nearest, ties up
          tq = (k - 1) * STEP_Q88 + (256 * d + w) / (2 * w);
        end
      end else begin
        r.region = REG_EXT;
        d  = xs - brk(LAST);
        tq = LAST * STEP_Q88 + (4 * d + 25) / 50;  // 0.05 Nm/A
      end
      if (tq > 32767) tq = 32767;
      if (tq < 0) tq = 0;
      r.torque = tq[TQ_W-1:0];
      return r;
    endfunction

    function void note_sample(input logic [IQ_W-1:0] bits);
      expected_q.push_back(predict(bits));
    endfunction

    function void check_result(input logic [M_TDATA_W-1:0] tdata);
      torque_res_t exp_r;
      logic [TQ_W-1:0]     act_tq;
      logic [REGION_W-1:0] act_rg;
      act_tq = tdata[TQ_W-1:0];
      act_rg = tdata[TQ_W +: REGION_W];
      if (expected_q.size() == 0) begin
        $error("unexpected torque transaction: tdata %h", tdata);
        n_errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      n_checked++;
      if (exp_r.region <= REG_EXT) region_hits[exp_r.region]++;
      if (act_tq !== exp_r.torque) begin
        $error("torque_estimate: expected %0d, actual %0d", exp_r.torque, act_tq);
        n_errors++;
      end
      if (act_rg !== exp_r.region) begin
        $error("region: expected %0d, actual %0d", exp_r.region, act_rg);
        n_errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // [15:0] iq_current
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;         // [14:0] torque_estimate, [16:15] region

  torque_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  current_to_torque_interpolator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Result side: check each torque transaction against the oldest prediction.
  // Sampling in the active region of the edge sees the pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Receiver back-pressure: a randomly redrawn mode, with occasional long stalls
  int rx_cycle;
  int rx_mode;
  int rx_stall_left;
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
    if (rx_stall_left == 0 && rx_mode != 0 && $urandom_range(0, 199) == 0)
      rx_stall_left = $urandom_range(10, 60);
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;                               // no stalls
        1: m_axis_tready <= ($urandom_range(0, 9) < 7);         // light stalls
        2: m_axis_tready <= ($urandom_range(0, 9) < 3);         // heavy stalls
        default: m_axis_tready <= ((rx_cycle % 5) < 3);         // fixed 3-of-5 pattern
      endcase
    end
  end

  // Watchdog: counts cycles with no transaction on either side
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drive one sample and hold it until the transaction completes
  task automatic send_sample(input logic [IQ_W-1:0] iq);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= iq;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(iq);
  endtask

  // Drop valid for an idle gap set by n; n == 0 keeps the stream back-to-back
  task automatic idle_gap(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Sample near a breakpoint (including the one just past the table in use, if any), within +/-2 LSB
  function automatic logic [IQ_W-1:0] near_breakpoint();
    int k, raw;
    k   = $urandom_range(0, (NPTS < MAX_POINTS) ? NPTS : LAST);
    raw = (int'(BRK_DECI[k]) * 16) / 10 + int'($urandom_range(0, 4)) - 2;
    return raw[IQ_W-1:0];
  endfunction

  function automatic logic [IQ_W-1:0] random_sample();
    int sel, raw;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      raw = $urandom_range(0, (int'(BRK_DECI[LAST]) * 16) / 10);   // table range
    end else if (sel < 55) begin
      return near_breakpoint();
    end else if (sel < 70) begin
      raw = -int'($urandom_range(1, 32768));                       // negative current
    end else begin
      return IQ_W'($urandom_range(0, 16'hffff));                   // whole field
    end
    return raw[IQ_W-1:0];
  endfunction

  // Directed corners: field extremes, zero, exact hits, either side of a hit, the table edge and extrapolation
  task automatic run_directed();
    logic [IQ_W-1:0] corners[$];
    corners = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff,
                16'sd8,            // inside the first segment
                16'sd176, 16'sd264, 16'sd352, 16'sd1600,   // exact breakpoint hits
                16'sd175, 16'sd177,                        // either side of a hit
                16'sd93, 16'sd92,                          // around 5.8 A
                16'sd2511, 16'sd2512, 16'sd2513,           // last breakpoint edge
                16'sd2560, 16'sd20000, 16'sh7ffe,          // extrapolation
                16'hffff, 16'h5555, 16'haaaa};
    foreach (corners[i]) begin
      send_sample(corners[i]);
      if (i % 5 == 4) idle_gap($urandom_range(1, 3));
    end
  endtask

  task automatic run_random();
    int sent, burst, gap;
    bit drained;
    sent    = 0;
    drained = 1'b0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
        send_sample(random_sample());
        sent++;
      end
      gap = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 8);
      idle_gap(gap);
      // Once mid-run, hold off until the pipeline is empty
      if (!drained && sent >= N_RANDOM / 2) begin
        drained = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random();

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.pending() > 0) begin
      $error("%0d torque results never arrived", sb.pending());
      sb.n_errors++;
    end

    $display("Checked %0d torque results: %0d clamped, %0d interpolated, %0d extrapolated",
             sb.n_checked, sb.region_hits[REG_NEG], sb.region_hits[REG_TAB],
             sb.region_hits[REG_EXT]);
    $display("Bursty sender, mixed receiver stalls, one full drain mid-run");
    if (sb.n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
